[hw/rtl/csmh_pkg.sv]
`default_nettype none
package csmh_pkg;

    // Default sizing of the block
    localparam int MAX_CUBOIDS_DEF = 128;
    localparam int SIDE_BITS_DEF   = 12;

    // Fixed port widths
    localparam int FIELD_BITS  = 12;
    localparam int HEIGHT_BITS = 19;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = {HEIGHT_BITS{1'b1}};

    // Result of the shared triple compare unit
    typedef struct packed {
        logic gt;    // x is lexicographically greater than y
        logic fits;  // every side of x is <= the matching side of y
    } t_cmp_res;

endpackage
`default_nettype wire

[hw/rtl/csmh_sort3.sv]
`default_nettype none
// Mask three sides and order them ascending; smallest side in the top bits.
module csmh_sort3 #(
    parameter int SW = csmh_pkg::SIDE_BITS_DEF
) (
    input  wire logic [csmh_pkg::FIELD_BITS-1:0] i_a,
    input  wire logic [csmh_pkg::FIELD_BITS-1:0] i_b,
    input  wire logic [csmh_pkg::FIELD_BITS-1:0] i_c,
    output logic [3*SW-1:0]                      o_triple
);
    logic [SW-1:0] a0, b0, c0, a1, b1, b2, c2, a3, b3;

    always_comb begin
        a0 = i_a[SW-1:0];
        b0 = i_b[SW-1:0];
        c0 = i_c[SW-1:0];
        // first exchange: a, b
        a1 = (a0 > b0) ? b0 : a0;
        b1 = (a0 > b0) ? a0 : b0;
        // second exchange: b, c
        b2 = (b1 > c0) ? c0 : b1;
        c2 = (b1 > c0) ? b1 : c0;
        // third exchange: a, b
        a3 = (a1 > b2) ? b2 : a1;
        b3 = (a1 > b2) ? a1 : b2;
        o_triple = {a3, b3, c2};
    end
endmodule
`default_nettype wire

[hw/rtl/csmh_cmp.sv]
`default_nettype none
// Shared compare unit: lexicographic order and side-by-side containment.
module csmh_cmp #(
    parameter int SW = csmh_pkg::SIDE_BITS_DEF
) (
    input  wire logic [3*SW-1:0] i_x,
    input  wire logic [3*SW-1:0] i_y,
    output csmh_pkg::t_cmp_res   o_res
);
    always_comb begin
        // smallest side sits in the top bits, so a plain compare is lexicographic
        o_res.gt   = (i_x > i_y);
        o_res.fits = (i_x[3*SW-1:2*SW] <= i_y[3*SW-1:2*SW]) &&
                     (i_x[2*SW-1:SW]   <= i_y[2*SW-1:SW]) &&
                     (i_x[SW-1:0]      <= i_y[SW-1:0]);
    end
endmodule
`default_nettype wire

[hw/rtl/cuboid_stack_max_height_unit.sv]
`default_nettype none
// Load: each item is sorted, then inserted by a walk that shifts larger entries up
// one place; the first item of a set is written directly, a dropped item not at all.
// Last item: after its load, the chain pass runs over the n entries, entry i against
// the i entries below it, bound by the single read port of the store; the result then
// goes to the output register once any earlier result is taken. No item is taken meanwhile.
// Reset (synchronous, active low) empties the set; the memories need no clearing.
module cuboid_stack_max_height_unit #(
    parameter int MAX_CUBOIDS = csmh_pkg::MAX_CUBOIDS_DEF,
    parameter int SIDE_BITS   = csmh_pkg::SIDE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [csmh_pkg::FIELD_BITS-1:0]     i_side_a,
    input  wire logic [csmh_pkg::FIELD_BITS-1:0]     i_side_b,
    input  wire logic [csmh_pkg::FIELD_BITS-1:0]     i_side_c,
    input  wire logic                                i_last,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [csmh_pkg::HEIGHT_BITS-1:0]         o_max_height,
    output logic                                     o_overflow
);
    localparam int SW = (SIDE_BITS < csmh_pkg::FIELD_BITS) ? SIDE_BITS
                                                           : csmh_pkg::FIELD_BITS;
    localparam int TW = 3 * SW;
    localparam int AW = (MAX_CUBOIDS > 1) ? $clog2(MAX_CUBOIDS) : 1;
    localparam int CW = $clog2(MAX_CUBOIDS + 1);
    localparam int HW = csmh_pkg::HEIGHT_BITS;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CUBOIDS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INS   = 7'b0000010,
        S_DTOP  = 7'b0000100,
        S_DGET  = 7'b0001000,
        S_DSCAN = 7'b0010000,
        S_DSUM  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Memories
    logic [TW-1:0] r_store [MAX_CUBOIDS];
    logic [HW-1:0] r_chain [MAX_CUBOIDS];
    logic [TW-1:0] r_st_rd;
    logic [HW-1:0] r_ch_rd;

    // Control and datapath registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_last, n_last;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [TW-1:0] r_new, n_new;
    logic [TW-1:0] r_top, n_top;
    logic [HW-1:0] r_under, n_under;
    logic [HW-1:0] r_best, n_best;
    logic          r_out_valid, n_out_valid;
    logic [HW-1:0] r_max_height, n_max_height;
    logic          r_overflow, n_overflow;

    logic                 in_acc;
    logic [TW-1:0]        sorted;
    logic [TW-1:0]        cmp_y;
    csmh_pkg::t_cmp_res   cmp;
    logic [AW-1:0]        raddr;
    logic                 st_we;
    logic [AW-1:0]        st_waddr;
    logic [TW-1:0]        st_wdata;
    logic                 ch_we;
    logic [HW:0]          sum;
    logic [HW-1:0]        h_sat;

    csmh_sort3 #(.SW(SW)) u_sort3 (
        .i_a      (i_side_a),
        .i_b      (i_side_b),
        .i_c      (i_side_c),
        .o_triple (sorted)
    );

    // Insertion compares against the new triple, the scan against the top cuboid
    assign cmp_y = (r_state == S_INS) ? r_new : r_top;

    csmh_cmp #(.SW(SW)) u_cmp (
        .i_x   (r_st_rd),
        .i_y   (cmp_y),
        .o_res (cmp)
    );

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Add the height of the top cuboid, saturate
    assign sum   = {1'b0, r_under} + (HW + 1)'(r_top[SW-1:0]);
    assign h_sat = sum[HW] ? csmh_pkg::HEIGHT_MAX : sum[HW-1:0];

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_last       = r_last;
        n_pos        = r_pos;
        n_i          = r_i;
        n_j          = r_j;
        n_new        = r_new;
        n_top        = r_top;
        n_under      = r_under;
        n_best       = r_best;
        n_out_valid  = r_out_valid;
        n_max_height = r_max_height;
        n_overflow   = r_overflow;
        raddr        = r_pos - AW'(1);
        st_we        = 1'b0;
        st_waddr     = r_pos;
        st_wdata     = r_new;
        ch_we        = 1'b0;

        // drop the result once it is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                raddr = AW'(r_count - CW'(1));
                if (in_acc) begin
                    n_new  = sorted;
                    n_last = i_last;
                    n_i    = '0;
                    n_best = '0;
                    if (r_count >= COUNT_FULL) begin
                        n_ovf   = 1'b1;
                        n_state = i_last ? S_DTOP : S_IDLE;
                    end else if (r_count == '0) begin
                        st_we    = 1'b1;
                        st_waddr = '0;
                        st_wdata = sorted;
                        n_count  = CW'(1);
                        n_state  = i_last ? S_DTOP : S_IDLE;
                    end else begin
                        n_pos   = AW'(r_count);
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                raddr = r_pos - AW'(2);
                st_we = 1'b1;
                if ((r_pos != '0) && cmp.gt) begin
                    // shift the larger entry up one place
                    st_wdata = r_st_rd;
                    n_pos    = r_pos - AW'(1);
                end else begin
                    st_wdata = r_new;
                    n_count  = r_count + CW'(1);
                    n_state  = r_last ? S_DTOP : S_IDLE;
                end
            end
            S_DTOP: begin
                raddr   = r_i;
                n_under = '0;
                n_state = S_DGET;
            end
            S_DGET: begin
                raddr = '0;
                n_top = r_st_rd;
                if (r_i == '0) begin
                    n_state = S_DSUM;
                end else begin
                    n_j     = AW'(1);
                    n_state = S_DSCAN;
                end
            end
            S_DSCAN: begin
                // entry j-1 is on the read port
                raddr = r_j;
                if (cmp.fits && (r_ch_rd > r_under)) begin
                    n_under = r_ch_rd;
                end
                if (r_j == r_i) begin
                    n_state = S_DSUM;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_DSUM: begin
                ch_we = 1'b1;
                if (h_sat > r_best) begin
                    n_best = h_sat;
                end
                if ((CW'(r_i) + CW'(1)) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_DTOP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_max_height = r_best;
                    n_overflow   = r_ovf;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_pos        <= n_pos;
        r_i          <= n_i;
        r_j          <= n_j;
        r_new        <= n_new;
        r_top        <= n_top;
        r_under      <= n_under;
        r_best       <= n_best;
        r_max_height <= n_max_height;
        r_overflow   <= n_overflow;
    end

    // Cuboid store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        r_st_rd <= r_store[raddr];
    end

    // Chain heights: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            r_chain[r_i] <= h_sat;
        end
        r_ch_rd <= r_chain[raddr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_max_height = r_max_height;
    assign o_overflow   = r_overflow;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("loaded count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSCAN) |-> ((r_j <= r_i) && (r_j != '0)))
        else $error("scan index out of range");

    a_ins_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_count != '0) && (r_count < COUNT_FULL))
        else $error("insertion into empty or full store");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result overwritten before transaction");
endmodule
`default_nettype wire
